// ===== design/lcdseq_pkg.sv =====
package lcdseq_pkg;

    localparam int NUMBER_WIDTH = 32;
    // Decimal digits needed for the widest operand: ceil(NUMBER_WIDTH * log10(2)).
    localparam int NUM_DIGITS = (NUMBER_WIDTH * 30103 + 99999) / 100000;
    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W = $clog2(NUMBER_WIDTH);
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [2:0] REQ_INIT    = 3'd0;
    localparam logic [2:0] REQ_COMMAND = 3'd1;
    localparam logic [2:0] REQ_DATA    = 3'd2;
    localparam logic [2:0] REQ_SETPOS  = 3'd3;
    localparam logic [2:0] REQ_NUMBER  = 3'd4;

    localparam logic [1:0] REG_FUNCTION_SET   = 2'd0;
    localparam logic [1:0] REG_DISPLAY_CTRL   = 2'd1;
    localparam logic [1:0] REG_ENTRY_MODE     = 2'd2;
    localparam logic [1:0] REG_SECOND_ROW_OFS = 2'd3;

    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_NUMBER = 2'd2;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    localparam logic [7:0] RESET_FUNCTION_SET = 8'h38;
    localparam logic [7:0] RESET_DISPLAY_CTRL = 8'h0C;
    localparam logic [7:0] RESET_ENTRY_MODE   = 8'h06;
    localparam logic [6:0] RESET_SECOND_ROW   = 7'd64;

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    localparam logic [15:0] DELAY_LEAD_US  = 16'd50000;
    localparam logic [11:0] DELAY_BASE_US  = 12'd1000;
    localparam logic [11:0] DELAY_SETUP_US = 12'd1050;
    localparam logic [11:0] DELAY_CLEAR_US = 12'd3000;

    typedef struct packed {
        logic [7:0] function_set;
        logic [7:0] display_control;
        logic [7:0] entry_mode;
        logic [6:0] second_row_offset;
    } lcdseq_cfg_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    rs;
        logic [7:0]              byte_val;
        logic [NUMBER_WIDTH-1:0] number;
    } lcdseq_cmd_t;

endpackage

// ===== design/char_lcd_command_sequencer_top.sv =====
// Channel   Handshake                      Word contents
// s_        s_valid / s_ready              req_type, byte_value, row, col, number
// m_        m_valid / m_ready              rs, lcd_byte, delay_before_us, delay_after_us, last
// cfg_      cfg_valid / cfg_ready (always)  cfg_index, cfg_data
//
// A command, data or position request leaves the queue into the back end, which registers its output word.
// Init gives four words, one per cycle while taken.
// A number leaves the queue, goes through bit-serial BCD conversion and has its leading zeros
// dropped, a zero keeping its last digit; its digits then show one per cycle while taken.
// A two-word queue lets the front keep accepting while the back waits on m_ready.
// Reset is synchronous and active low; it empties the queue and the output register.
module char_lcd_command_sequencer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_req_type,
    input  logic [7:0]                         s_byte_value,
    input  logic [1:0]                         s_row,
    input  logic [5:0]                         s_col,
    input  logic [lcdseq_pkg::NUMBER_WIDTH-1:0] s_number,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_rs,
    output logic [7:0]                         m_lcd_byte,
    output logic [15:0]                        m_delay_before_us,
    output logic [11:0]                        m_delay_after_us,
    output logic                               m_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [7:0]                         cfg_data
);

    lcdseq_pkg::lcdseq_cfg_t cfg_reg, cfg_next;
    lcdseq_pkg::lcdseq_cmd_t front_cmd;
    lcdseq_pkg::lcdseq_cmd_t queue_cmd;
    logic                    push;
    logic                    pop;
    logic                    queue_full;
    logic                    queue_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lcdseq_pkg::REG_FUNCTION_SET:   cfg_next.function_set = cfg_data;
                lcdseq_pkg::REG_DISPLAY_CTRL:   cfg_next.display_control = cfg_data;
                lcdseq_pkg::REG_ENTRY_MODE:     cfg_next.entry_mode = cfg_data;
                lcdseq_pkg::REG_SECOND_ROW_OFS: cfg_next.second_row_offset = cfg_data[6:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.function_set      <= lcdseq_pkg::RESET_FUNCTION_SET;
            cfg_reg.display_control   <= lcdseq_pkg::RESET_DISPLAY_CTRL;
            cfg_reg.entry_mode        <= lcdseq_pkg::RESET_ENTRY_MODE;
            cfg_reg.second_row_offset <= lcdseq_pkg::RESET_SECOND_ROW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcdseq_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_number     (s_number),
        .cfg          (cfg_reg),
        .fifo_full    (queue_full),
        .push         (push),
        .cmd          (front_cmd)
    );

    lcdseq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_valid),
        .pop_cmd   (queue_cmd)
    );

    lcdseq_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .cmd_valid         (queue_valid),
        .cmd               (queue_cmd),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rs              (m_rs),
        .m_lcd_byte        (m_lcd_byte),
        .m_delay_before_us (m_delay_before_us),
        .m_delay_after_us  (m_delay_after_us),
        .m_last            (m_last)
    );

endmodule

// ===== design/lcdseq_front.sv =====
module lcdseq_front (
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_req_type,
    input  logic [7:0]                         s_byte_value,
    input  logic [1:0]                         s_row,
    input  logic [5:0]                         s_col,
    input  logic [lcdseq_pkg::NUMBER_WIDTH-1:0] s_number,
    input  lcdseq_pkg::lcdseq_cfg_t            cfg,
    input  logic                               fifo_full,
    output logic                               push,
    output lcdseq_pkg::lcdseq_cmd_t            cmd
);

    logic       keep;
    logic [7:0] row_base;

    always_comb begin
        row_base = (s_row == lcdseq_pkg::ROW_SECOND) ? {1'b0, cfg.second_row_offset} : 8'd0;
        keep = 1'b0;
        cmd.kind = lcdseq_pkg::KIND_SINGLE;
        cmd.rs = 1'b0;
        cmd.byte_val = s_byte_value;
        cmd.number = s_number;
        case (s_req_type)
            lcdseq_pkg::REQ_INIT: begin
                keep = 1'b1;
                cmd.kind = lcdseq_pkg::KIND_INIT;
            end
            lcdseq_pkg::REQ_COMMAND: begin
                keep = 1'b1;
            end
            lcdseq_pkg::REQ_DATA: begin
                keep = 1'b1;
                cmd.rs = 1'b1;
            end
            lcdseq_pkg::REQ_SETPOS: begin
                keep = (s_row == lcdseq_pkg::ROW_FIRST) || (s_row == lcdseq_pkg::ROW_SECOND);
                cmd.byte_val = lcdseq_pkg::CMD_SET_DDRAM + row_base + {2'b00, s_col} - 8'd1;
            end
            lcdseq_pkg::REQ_NUMBER: begin
                keep = 1'b1;
                cmd.kind = lcdseq_pkg::KIND_NUMBER;
                cmd.rs = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Requests that produce no writes are taken and dropped here.
    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready && keep;

endmodule

// ===== design/lcdseq_fifo.sv =====
module lcdseq_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lcdseq_pkg::lcdseq_cmd_t push_cmd,
    output logic                    full,
    input  logic                    pop,
    output logic                    not_empty,
    output lcdseq_pkg::lcdseq_cmd_t pop_cmd
);

    lcdseq_pkg::lcdseq_cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/lcdseq_back.sv =====
module lcdseq_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lcdseq_pkg::lcdseq_cfg_t cfg,
    input  logic                    cmd_valid,
    input  lcdseq_pkg::lcdseq_cmd_t cmd,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_rs,
    output logic [7:0]              m_lcd_byte,
    output logic [15:0]             m_delay_before_us,
    output logic [11:0]             m_delay_after_us,
    output logic                    m_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_SINGLE = 3'd2;
    localparam logic [2:0] ST_CONV   = 3'd3;
    localparam logic [2:0] ST_SKIP   = 3'd4;
    localparam logic [2:0] ST_DIGIT  = 3'd5;

    localparam int BCD_W = lcdseq_pkg::BCD_W;
    localparam int NW    = lcdseq_pkg::NUMBER_WIDTH;
    localparam int BCW   = lcdseq_pkg::BIT_CNT_W;
    localparam int DCW   = lcdseq_pkg::DIG_CNT_W;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [BCW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [NW-1:0]    num_reg, num_next;
    logic             rs_reg, rs_next;
    logic [7:0]       byte_reg, byte_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_rs_reg, m_rs_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic [15:0]      m_before_reg, m_before_next;
    logic [11:0]      m_after_reg, m_after_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             emit;
    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       top_digit;

    assign out_free  = !m_valid_reg || m_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Double-dabble correction: every BCD digit of five or more gets three added.
    always_comb begin
        for (int i = 0; i < lcdseq_pkg::NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        bcd_next      = bcd_reg;
        num_next      = num_reg;
        rs_next       = rs_reg;
        byte_next     = byte_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        m_rs_next     = m_rs_reg;
        m_byte_next   = m_byte_reg;
        m_before_next = m_before_reg;
        m_after_next  = m_after_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    pop       = 1'b1;
                    rs_next   = cmd.rs;
                    byte_next = cmd.byte_val;
                    num_next  = cmd.number;
                    case (cmd.kind)
                        lcdseq_pkg::KIND_INIT: begin
                            state_next = ST_INIT;
                            step_next  = 2'd0;
                        end
                        lcdseq_pkg::KIND_NUMBER: begin
                            state_next   = ST_CONV;
                            bcd_next     = '0;
                            bit_cnt_next = '0;
                        end
                        default: begin
                            state_next = ST_SINGLE;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    m_rs_next     = 1'b0;
                    m_before_next = 16'd0;
                    m_last_next   = 1'b0;
                    step_next     = step_reg + 2'd1;
                    case (step_reg)
                        2'd0: begin
                            m_byte_next   = cfg.function_set;
                            m_before_next = lcdseq_pkg::DELAY_LEAD_US;
                            m_after_next  = lcdseq_pkg::DELAY_SETUP_US;
                        end
                        2'd1: begin
                            m_byte_next  = cfg.display_control;
                            m_after_next = lcdseq_pkg::DELAY_SETUP_US;
                        end
                        2'd2: begin
                            m_byte_next  = lcdseq_pkg::CMD_CLEAR;
                            m_after_next = lcdseq_pkg::DELAY_CLEAR_US;
                        end
                        default: begin
                            m_byte_next  = cfg.entry_mode;
                            m_after_next = lcdseq_pkg::DELAY_BASE_US;
                            m_last_next  = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    emit          = 1'b1;
                    m_rs_next     = rs_reg;
                    m_byte_next   = byte_reg;
                    m_before_next = 16'd0;
                    m_after_next  = lcdseq_pkg::DELAY_BASE_US;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CONV: begin
                bcd_next     = {bcd_adj[BCD_W-2:0], num_reg[NW-1]};
                num_next     = {num_reg[NW-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BCW'(1);
                if (bit_cnt_reg == BCW'(NW - 1)) begin
                    state_next   = ST_SKIP;
                    dig_cnt_next = DCW'(lcdseq_pkg::NUM_DIGITS);
                end
            end
            ST_SKIP: begin
                // Leading zeros are dropped, but a zero operand keeps its last digit.
                if ((top_digit == 4'd0) && (dig_cnt_reg != DCW'(1))) begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DCW'(1);
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    m_rs_next     = 1'b1;
                    m_byte_next   = lcdseq_pkg::ASCII_ZERO + {4'd0, top_digit};
                    m_before_next = 16'd0;
                    m_after_next  = lcdseq_pkg::DELAY_BASE_US;
                    m_last_next   = (dig_cnt_reg == DCW'(1));
                    bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next  = dig_cnt_reg - DCW'(1);
                    if (dig_cnt_reg == DCW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= 2'd0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg      <= bcd_next;
        num_reg      <= num_next;
        rs_reg       <= rs_next;
        byte_reg     <= byte_next;
        m_rs_reg     <= m_rs_next;
        m_byte_reg   <= m_byte_next;
        m_before_reg <= m_before_next;
        m_after_reg  <= m_after_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_rs              = m_rs_reg;
    assign m_lcd_byte        = m_byte_reg;
    assign m_delay_before_us = m_before_reg;
    assign m_delay_after_us  = m_after_reg;
    assign m_last            = m_last_reg;

endmodule

// ===== design/lcdseq_checker.sv =====
module lcdseq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_rs,
    input logic [7:0]  m_lcd_byte,
    input logic [15:0] m_delay_before_us,
    input logic [11:0] m_delay_after_us,
    input logic        m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lcd_byte) && $stable(m_last))
        else $error("output word changed while stalled");

    a_data_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rs |-> m_delay_before_us == 16'd0 && m_delay_after_us == 12'd1000)
        else $error("data write with wrong delays");

    a_clear_mid_init: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_delay_after_us == 12'd3000 |-> m_lcd_byte == 8'h01 && !m_last && !m_rs)
        else $error("long wait on a word other than clear in init");

    a_lead_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_delay_before_us != 16'd0 |->
            m_delay_before_us == 16'd50000 && m_delay_after_us == 12'd1050 && !m_last && !m_rs)
        else $error("lead-in wait on a word other than the first init write");

endmodule

bind char_lcd_command_sequencer_top lcdseq_checker u_lcdseq_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_rs              (m_rs),
    .m_lcd_byte        (m_lcd_byte),
    .m_delay_before_us (m_delay_before_us),
    .m_delay_after_us  (m_delay_after_us),
    .m_last            (m_last)
);
